@@ rtl/pip_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the point-in-polygon test block.
// Used by the vertex store, the serial multiply-divide unit and the top level.
package pip_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_COORD_WIDTH  = 16;

	localparam int VIDX_W = 6;
	localparam int CFG_W  = 7;
	localparam int OUT_DW = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

endpackage

@@ rtl/point_in_polygon_test.sv @@
`timescale 1ns / 1ps
// Point-in-polygon test by crossing number over a stored vertex list. A load
// transaction writes one vertex and gives no result. A query transaction walks
// the polygon edge by edge, reading one vertex per edge from the vertex store; an
// edge that spans the query x goes through the bit-serial multiply-divide unit. A
// query ends early when a hit lands on the query point. One query is worked on at
// a time; its result waits in an output register while the next transaction is
// accepted. Depends on pip_pkg, pip_store and pip_serdiv.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
	parameter int COORD_WIDTH  = pip_pkg::DEF_COORD_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vertex_index, coord_x, coord_y, zero padding
	input  logic [((pip_pkg::VIDX_W + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// cmd
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// inside_res, zero padding
	output logic [pip_pkg::OUT_DW-1:0] m_axis_tdata,
	input  logic cfg_wr_en,
	input  logic [pip_pkg::CFG_W-1:0] cfg_wr_data
);
	import pip_pkg::*;

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int CW   = COORD_WIDTH;
	localparam int MW   = CW + 1;
	localparam int HW   = CW + 2;
	localparam int IXW  = (AW > VIDX_W) ? AW : VIDX_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FETCH0 = 4'd1;
	localparam logic [3:0] S_FETCH1 = 4'd2;
	localparam logic [3:0] S_FETCH2 = 4'd3;
	localparam logic [3:0] S_EDGE   = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_ACC    = 4'd6;
	localparam logic [3:0] S_NEXT   = 4'd7;
	localparam logic [3:0] S_LOAD   = 4'd8;
	localparam logic [3:0] S_RESULT = 4'd9;

	logic [3:0]            state_q;
	logic [CFG_W-1:0]      vertex_count_q;
	logic [CNTW-1:0]       n_q;
	logic [AW-1:0]         edge_q;
	logic                  parity_q;
	logic                  res_q;
	logic                  m_tvalid_q;
	logic                  out_res_q;
	logic signed [CW-1:0]  qx_q;
	logic signed [CW-1:0]  qy_q;
	logic [2*CW-1:0]       prev_q;
	logic [2*CW-1:0]       cur_q;
	logic [2*CW-1:0]       nxt_q;
	logic signed [HW-1:0]  hit_q;

	logic                  in_acc;
	logic                  in_cmd;
	logic [VIDX_W-1:0]     in_idx;
	logic [IXW-1:0]        in_idx_ext;
	logic signed [CW-1:0]  in_x;
	logic signed [CW-1:0]  in_y;
	logic                  idx_ok;
	logic [CNTW-1:0]       n_in;

	logic                  mem_we;
	logic [AW-1:0]         rd_addr;
	logic [2*CW-1:0]       rd_data;

	logic signed [CW-1:0]  sx;
	logic signed [CW-1:0]  sy;
	logic signed [CW-1:0]  ex;
	logic signed [CW-1:0]  ey;
	logic signed [CW-1:0]  px;
	logic                  vert_hit;
	logic                  span;
	logic signed [MW-1:0]  a_d;
	logic signed [MW-1:0]  b_d;
	logic signed [MW-1:0]  d_d;
	logic [MW-1:0]         a_mag;
	logic [MW-1:0]         b_mag;
	logic [MW-1:0]         d_mag;
	logic                  div_start;
	logic                  div_done;
	logic signed [MW:0]    div_quot;
	logic signed [HW-1:0]  hit_calc;
	logic signed [HW-1:0]  qy_ext;
	logic [CNTW:0]         e2;
	logic                  last_edge;
	logic                  out_free;

	assign in_idx     = s_axis_tdata[VIDX_W-1:0];
	assign in_x       = signed'(s_axis_tdata[VIDX_W +: CW]);
	assign in_y       = signed'(s_axis_tdata[VIDX_W + CW +: CW]);
	assign in_cmd     = s_axis_tuser;
	assign in_idx_ext = IXW'(in_idx);
	assign idx_ok     = int'(in_idx) < MAX_VERTICES;
	assign n_in       = (int'(vertex_count_q) > MAX_VERTICES) ? CNTW'(MAX_VERTICES)
	                                                         : CNTW'(vertex_count_q);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign mem_we        = in_acc && (in_cmd == CMD_LOAD) && idx_ok;

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {{(OUT_DW - 1){1'b0}}, out_res_q};
	assign out_free      = !m_tvalid_q || m_axis_tready;

	pip_store #(
		.DEPTH  (MAX_VERTICES),
		.DATA_W (2 * CW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (in_idx_ext[AW-1:0]),
		.wr_data ({in_y, in_x}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign sx = signed'(cur_q[CW-1:0]);
	assign sy = signed'(cur_q[2*CW-1:CW]);
	assign ex = signed'(nxt_q[CW-1:0]);
	assign ey = signed'(nxt_q[2*CW-1:CW]);
	assign px = signed'(prev_q[CW-1:0]);

	// A vertex on the line counts when its neighbours do not both lie strictly on one side.
	assign vert_hit = (sx == qx_q) && (ex <= qx_q || px <= qx_q) && (ex >= qx_q || px >= qx_q);
	assign span     = (sx != qx_q) && (ex != qx_q) &&
	                  (sx >= qx_q || ex >= qx_q) && (sx <= qx_q || ex <= qx_q);

	assign a_d   = MW'(qx_q) - MW'(sx);
	assign b_d   = MW'(ey) - MW'(sy);
	assign d_d   = MW'(ex) - MW'(sx);
	assign a_mag = a_d[MW-1] ? -a_d : a_d;
	assign b_mag = b_d[MW-1] ? -b_d : b_d;
	assign d_mag = d_d[MW-1] ? -d_d : d_d;

	assign div_start = (state_q == S_EDGE) && !vert_hit && span;

	pip_serdiv #(
		.W (MW)
	) u_serdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a_mag  (a_mag),
		.b_mag  (b_mag),
		.d_mag  (d_mag),
		.neg    (a_d[MW-1] ^ b_d[MW-1] ^ d_d[MW-1]),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign hit_calc  = HW'(sy) + div_quot;
	assign qy_ext    = HW'(qy_q);
	assign e2        = (CNTW + 1)'(edge_q) + (CNTW + 1)'(2);
	assign last_edge = (n_q == CNTW'(2)) || (CNTW'(edge_q) == n_q - CNTW'(1));

	always_comb begin
		case (state_q)
			S_IDLE:   rd_addr = AW'(n_in - CNTW'(1));
			S_FETCH0: rd_addr = '0;
			S_FETCH1: rd_addr = AW'(1);
			S_NEXT:   rd_addr = (e2 == (CNTW + 1)'(n_q)) ? '0 : AW'(e2);
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			edge_q     <= '0;
			parity_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_cmd == CMD_QUERY) begin
						state_q <= (n_in == '0) ? S_RESULT : S_FETCH0;
					end
				end
				S_FETCH0: begin
					state_q <= S_FETCH1;
				end
				S_FETCH1: begin
					state_q <= (n_q == CNTW'(1)) ? S_RESULT : S_FETCH2;
				end
				S_FETCH2: begin
					edge_q   <= '0;
					parity_q <= 1'b0;
					state_q  <= S_EDGE;
				end
				S_EDGE: begin
					if (vert_hit) begin
						state_q <= S_ACC;
					end else if (span) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (hit_q == qy_ext) begin
						state_q <= S_RESULT;
					end else begin
						if (hit_q < qy_ext) begin
							parity_q <= !parity_q;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (last_edge) begin
						state_q <= S_RESULT;
					end else begin
						edge_q  <= edge_q + AW'(1);
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_EDGE;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_cmd == CMD_QUERY) begin
					qx_q  <= in_x;
					qy_q  <= in_y;
					n_q   <= n_in;
					res_q <= 1'b0;
				end
			end
			S_FETCH0: begin
				prev_q <= rd_data;
			end
			S_FETCH1: begin
				cur_q <= rd_data;
				res_q <= (rd_data == {qy_q, qx_q});
			end
			S_FETCH2: begin
				nxt_q <= rd_data;
			end
			S_EDGE: begin
				hit_q <= HW'(sy);
			end
			S_DIV: begin
				if (div_done) begin
					hit_q <= hit_calc;
				end
			end
			S_ACC: begin
				if (hit_q == qy_ext) begin
					res_q <= 1'b1;
				end
			end
			S_NEXT: begin
				if (last_edge) begin
					res_q <= (n_q == CNTW'(2)) ? 1'b0 : parity_q;
				end else begin
					prev_q <= cur_q;
					cur_q  <= nxt_q;
				end
			end
			S_LOAD: begin
				nxt_q <= rd_data;
			end
			S_RESULT: begin
				if (out_free) begin
					out_res_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("Divider finished outside the wait state.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_RESULT)
		else $error("Result raised without a finished query.");

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EDGE) |-> CNTW'(edge_q) < n_q)
		else $error("Edge index beyond the vertex count.");
`endif

endmodule

@@ rtl/pip_store.sv @@
`timescale 1ns / 1ps
// Vertex store: one write port and one registered read port.
// Depends on pip_pkg for the default depth and coordinate width.
module pip_store #(
	parameter int DEPTH  = pip_pkg::DEF_MAX_VERTICES,
	parameter int DATA_W = 2 * pip_pkg::DEF_COORD_WIDTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);
	import pip_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/pip_serdiv.sv @@
`timescale 1ns / 1ps
// Bit-serial unit: shift-add multiply of two magnitudes, then restoring division
// of the product, one bit per cycle. Depends on pip_pkg for the default width.
module pip_serdiv #(
	parameter int W = pip_pkg::DEF_COORD_WIDTH + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        a_mag,
	input  logic [W-1:0]        b_mag,
	input  logic [W-1:0]        d_mag,
	input  logic                neg,
	output logic                done,
	output logic signed [W:0]   quot
);
	import pip_pkg::*;

	localparam int CNTW = $clog2(2 * W);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	logic [1:0]      phase_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [2*W-1:0]  p_q;
	logic [W-1:0]    mcand_q;
	logic [W-1:0]    div_q;
	logic [W-1:0]    rem_q;
	logic            neg_q;

	logic [W:0]        mul_sum;
	logic [W:0]        trial;
	logic [W:0]        diff;
	logic              ge;
	logic signed [W:0] qmag;

	assign mul_sum = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, mcand_q} : '0);
	assign trial   = {rem_q, p_q[2*W-1]};
	assign diff    = trial - {1'b0, div_q};
	assign ge      = trial >= {1'b0, div_q};
	assign qmag    = $signed({1'b0, p_q[W-1:0]});
	assign quot    = neg_q ? -qmag : qmag;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: begin
					if (cnt_q == CNTW'(W - 1)) begin
						phase_q <= PH_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				PH_DIV: begin
					if (cnt_q == CNTW'(2 * W - 1)) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					p_q     <= {{W{1'b0}}, a_mag};
					mcand_q <= b_mag;
					div_q   <= d_mag;
					neg_q   <= neg;
				end
			end
			PH_MUL: begin
				p_q   <= {mul_sum, p_q[W-1:1]};
				rem_q <= '0;
			end
			PH_DIV: begin
				rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
				p_q   <= {p_q[2*W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> phase_q == PH_IDLE)
		else $error("Divider started while busy.");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIV) |-> div_q != '0)
		else $error("Division by zero in progress.");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q)
		else $error("Remainder not below divisor at completion.");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for point_in_polygon_test: loads vertex lists, sends query points and
// compares every inside flag with an in-bench crossing-number predictor. Depends on pip_pkg.
module tb_top;

	import pip_pkg::*;

	localparam int NVERT     = DEF_MAX_VERTICES;
	localparam int CW        = DEF_COORD_WIDTH;
	localparam int DW        = ((VIDX_W + 2 * CW + 7) / 8) * 8;
	localparam int LIMIT     = 2000000;
	localparam int ITEM_GOAL = 270;

	typedef struct {
		logic                 cmd;
		logic [VIDX_W-1:0]    slot;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} pip_item_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [DW-1:0] s_axis_tdata = '0;
	logic          s_axis_tuser = 1'b0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;
	logic          cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	pip_item_t load_query_q[$];
	logic      inside_exp[$];

	// Predictor state.
	logic signed [CW-1:0] vtx_x [NVERT];
	logic signed [CW-1:0] vtx_y [NVERT];
	int unsigned          poly_count = CFG_RESET;

	// Generator view of the store.
	logic signed [CW-1:0] gen_x [NVERT];
	logic signed [CW-1:0] gen_y [NVERT];
	bit                   slot_loaded [NVERT];

	int  err_cnt = 0;
	int  res_cnt = 0;
	int  txn_cnt = 0;
	int  queued  = 0;
	int  settings_cnt = 0;
	int  cyc = 0;
	bit  hold_arm = 1'b0;

	point_in_polygon_test DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit edge_crossing(input int s, input int e, input int p,
			input longint qx, output longint hy);
		longint sx, sy, ex, ey, px;
		sx = vtx_x[s];
		sy = vtx_y[s];
		ex = vtx_x[e];
		ey = vtx_y[e];
		px = vtx_x[p];
		hy = 0;
		if (sx == qx) begin
			if ((ex <= qx || px <= qx) && (ex >= qx || px >= qx)) begin
				hy = sy;
				return 1'b1;
			end
		end else if (ex != qx) begin
			if ((sx >= qx || ex >= qx) && (sx <= qx || ex <= qx) && ex != sx) begin
				hy = sy + ((qx - sx) * (ey - sy)) / (ex - sx);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic point_inside(input longint qx, input longint qy);
		int     n;
		int     crossings;
		int     nx;
		int     pv;
		longint hy;
		n = (poly_count > NVERT) ? NVERT : int'(poly_count);
		crossings = 0;
		if (n == 0)
			return 1'b0;
		if (n == 1)
			return (longint'(vtx_x[0]) == qx && longint'(vtx_y[0]) == qy);
		if (n == 2) begin
			if (edge_crossing(0, 1, 1, qx, hy))
				return (hy == qy);
			return 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			nx = (i + 1 == n) ? 0 : i + 1;
			pv = (i == 0) ? n - 1 : i - 1;
			if (edge_crossing(i, nx, pv, qx, hy)) begin
				if (hy == qy)
					return 1'b1;
				if (hy < qy)
					crossings++;
			end
		end
		return crossings[0];
	endfunction

	// Sender: bursts of random length separated by random gaps.
	pip_item_t cur_item;
	int        burst_left = 0;
	int        gap_left = 0;
	logic      next_valid;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				txn_cnt++;
				if (cur_item.cmd == CMD_LOAD) begin
					vtx_x[cur_item.slot] = cur_item.x;
					vtx_y[cur_item.slot] = cur_item.y;
				end else begin
					inside_exp.push_back(point_inside(cur_item.x, cur_item.y));
				end
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (load_query_q.size() > 0) begin
					cur_item = load_query_q.pop_front();
					next_valid = 1'b1;
					s_axis_tdata <= {{(DW - VIDX_W - 2 * CW){1'b0}},
						cur_item.y, cur_item.x, cur_item.slot};
					s_axis_tuser <= cur_item.cmd;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
				s_axis_tvalid <= next_valid;
			end
		end
	end

	// Receiver: random stalls, stall-free stretches and one long hold-off.
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	int   stall_left = 0;
	int   free_left = 0;
	logic rdy;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_arm && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 1500;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (free_left > 0) begin
				free_left--;
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				case ($urandom_range(0, 9))
					0, 1: stall_left = $urandom_range(1, 20);
					2: free_left = $urandom_range(50, 300);
					default: ;
				endcase
			end
			m_axis_tready <= rdy;
		end
	end

	logic exp_inside;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			res_cnt++;
			if (inside_exp.size() == 0) begin
				$error("result transaction with nothing expected: inside_res=%0b", m_axis_tdata[0]);
				err_cnt++;
			end else begin
				exp_inside = inside_exp.pop_front();
				if (m_axis_tdata[0] !== exp_inside) begin
					$error("inside_res: expected %0b, actual %0b", exp_inside, m_axis_tdata[0]);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic push_load(input int slot, input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		pip_item_t it;
		it.cmd = CMD_LOAD;
		it.slot = slot[VIDX_W-1:0];
		it.x = x;
		it.y = y;
		load_query_q.push_back(it);
		gen_x[slot] = x;
		gen_y[slot] = y;
		slot_loaded[slot] = 1'b1;
		queued++;
	endtask

	task automatic push_query(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		pip_item_t it;
		it.cmd = CMD_QUERY;
		it.slot = VIDX_W'($urandom);
		it.x = x;
		it.y = y;
		load_query_q.push_back(it);
		queued++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (load_query_q.size() != 0 || s_axis_tvalid || inside_exp.size() != 0);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_count(input int unsigned value);
		wait_drained();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[CFG_W-1:0];
		poly_count = value & 7'h7F;
		settings_cnt++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord(input int span);
		if (span >= 32767)
			return CW'($urandom);
		return CW'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_query(input int m, input int span);
		int k;
		k = (m > 0) ? $urandom_range(0, m - 1) : 0;
		case ($urandom_range(0, 9))
			0, 1, 2: push_query(gen_x[k], rand_coord(span));
			3: push_query(gen_x[k], gen_y[k]);
			4: push_query(CW'($urandom), CW'($urandom));
			5: push_query($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
				$urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
			default: push_query(rand_coord(span), rand_coord(span));
		endcase
	endtask

	int phase_no;
	int cnt;
	int m;
	int span;
	int nq;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single vertex with the count left at its reset value.
		push_load(0, 16'sh8000, 16'sh7FFF);
		push_query(16'sh8000, 16'sh7FFF);
		push_query(16'sh8000, 16'sh7FFE);
		push_query(16'sh7FFF, 16'sh8000);

		// Two vertices: only a hit exactly at the query y counts.
		write_count(2);
		push_load(0, 0, 0);
		push_load(1, 10, 10);
		push_query(5, 5);
		push_query(5, 4);
		push_query(0, 0);
		push_query(-5, -5);

		// Square: interior, exterior, vertex and edges.
		write_count(4);
		push_load(0, -100, -100);
		push_load(1, 100, -100);
		push_load(2, 100, 100);
		push_load(3, -100, 100);
		push_query(0, 0);
		push_query(200, 0);
		push_query(100, 100);
		push_query(-100, 0);
		push_query(0, -100);
		push_query(16'sh7FFF, 16'sh8000);

		write_count(0);
		push_query(0, 0);

		phase_no = 0;
		while (queued < ITEM_GOAL) begin
			case (phase_no)
				0: cnt = 1;
				1: cnt = 64;
				2: cnt = 127;
				3: cnt = 3;
				4: cnt = 65;
				default: begin
					case ($urandom_range(0, 9))
						0: cnt = 2;
						1: cnt = $urandom_range(9, 20);
						2: cnt = $urandom_range(0, 1);
						default: cnt = $urandom_range(3, 8);
					endcase
				end
			endcase
			write_count(cnt);
			m = (cnt > NVERT) ? NVERT : cnt;
			case ($urandom_range(0, 2))
				0: span = 8;
				1: span = 200;
				default: span = 32767;
			endcase
			if (m <= 20) begin
				for (int i = 0; i < m; i++)
					push_load(i, rand_coord(span), rand_coord(span));
				nq = (phase_no == 3) ? 10 : $urandom_range(4, 10);
			end else begin
				for (int i = 0; i < m; i++)
					if (!slot_loaded[i])
						push_load(i, rand_coord(span), rand_coord(span));
				repeat (4) push_load($urandom_range(0, m - 1), rand_coord(span), rand_coord(span));
				nq = 3;
			end
			if (phase_no == 3)
				hold_arm = 1'b1;
			repeat (nq) begin
				if (m <= 20 && $urandom_range(0, 7) == 0)
					push_load($urandom_range(0, NVERT - 1), rand_coord(span), rand_coord(span));
				random_query(m, span);
			end
			phase_no++;
		end

		wait_drained();
		repeat (100) @(negedge clk);
		$display("tb_top: %0d transactions sent, %0d inside flags checked", txn_cnt, res_cnt);
		$display("tb_top: %0d vertex counts written, from 0 to 127", settings_cnt);
		if (err_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
